// ----- hdl/i2cbm_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cbm_pkg: shared types and constants for the I2C bit-level master
// Command codes, beat layouts and timing constants used by the engine and
// the streaming wrapper.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

    // Command codes carried in the mode field
    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4,
        CMD_CLEAR = 3'd5
    } t_cmd;

    localparam int          DELAY_W     = 16;
    localparam int          DATA_W      = 8;
    localparam int          TDATA_W     = 16;
    localparam logic [3:0]  BIT_COUNT   = 4'd9;   // eight data clocks plus ACK clock
    localparam logic [3:0]  ACK_BIT     = 4'd8;
    localparam logic [2:0]  TOP_BIT     = 3'd7;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd8;

    // Input beat, last field in the lowest bits
    typedef struct packed {
        logic              sda_sample;
        logic              master_ack;
        logic [DATA_W-1:0] tx_byte;
        logic [2:0]        mode;
    } t_item;

    // Result beat, last field in the lowest bits
    typedef struct packed {
        logic              rejected;
        logic              ack_received;
        logic [DATA_W-1:0] rx_data;
        logic              done_res;
        logic              busy_res;
        logic              sda_pull_low;
        logic              scl_pull_low;
    } t_result;

    localparam int ITEM_W   = $bits(t_item);
    localparam int RESULT_W = $bits(t_result);

endpackage

// ----- hdl/i2cbm_engine.sv -----
// ----------------------------------------------------------------------------
// i2cbm_engine: I2C master line sequencer
// Holds the command state and advances it by one tick per step, producing
// the line drives and status for that tick.
// ----------------------------------------------------------------------------
module i2cbm_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  i2cbm_pkg::t_item              i_item,
    input  logic [i2cbm_pkg::DELAY_W-1:0] i_delay,
    output i2cbm_pkg::t_result            o_res
);

    // State registers
    i2cbm_pkg::t_cmd                  r_cmd, n_cmd;
    logic [2:0]                       r_sub, n_sub;
    logic [3:0]                       r_bit, n_bit;
    logic [i2cbm_pkg::DELAY_W-1:0]    r_delay, n_delay;
    logic [i2cbm_pkg::DATA_W-1:0]     r_shift, n_shift;
    logic                             r_scl, n_scl;
    logic                             r_sda, n_sda;
    logic                             r_ack, n_ack;
    logic                             r_send_ack, n_send_ack;
    logic [i2cbm_pkg::DATA_W-1:0]     r_rx, n_rx;

    // Action position used this tick (fresh command or held one)
    i2cbm_pkg::t_cmd                  p_cmd;
    logic [2:0]                       p_sub;
    logic [3:0]                       p_bit;
    logic [i2cbm_pkg::DATA_W-1:0]     p_shift;
    logic                             p_send_ack;

    // Action results
    logic                             w_ok;
    logic [2:0]                       w_sub;
    logic [3:0]                       w_bit;
    logic [i2cbm_pkg::DATA_W-1:0]     w_shift;
    logic                             w_scl;
    logic                             w_sda;
    logic                             w_ack;

    logic                             w_valid_cmd;
    logic                             w_idle;
    logic [i2cbm_pkg::DELAY_W-1:0]    w_eff_delay;
    logic [2:0]                       w_bit_idx;
    logic                             w_done;
    logic                             w_rej;

    assign w_idle      = (r_cmd == i2cbm_pkg::CMD_IDLE);
    assign w_valid_cmd = i_item.mode inside {[i2cbm_pkg::CMD_START : i2cbm_pkg::CMD_CLEAR]};
    assign w_eff_delay = (i_delay == '0) ? i2cbm_pkg::DELAY_W'(1) : i_delay;

    // Pick the action position: a new command starts at its first action
    always_comb begin
        if (w_idle) begin
            p_cmd      = i2cbm_pkg::t_cmd'(i_item.mode);
            p_sub      = '0;
            p_bit      = '0;
            p_shift    = (i_item.mode == i2cbm_pkg::CMD_WRITE) ? i_item.tx_byte : '0;
            p_send_ack = i_item.master_ack;
        end else begin
            p_cmd      = r_cmd;
            p_sub      = r_sub;
            p_bit      = r_bit;
            p_shift    = r_shift;
            p_send_ack = r_send_ack;
        end
    end

    assign w_bit_idx = i2cbm_pkg::TOP_BIT - p_bit[2:0];

    // Carry out one action of the current command
    always_comb begin
        w_ok    = 1'b1;
        w_sub   = p_sub;
        w_bit   = p_bit;
        w_shift = p_shift;
        w_scl   = r_scl;
        w_sda   = r_sda;
        w_ack   = r_ack;
        case (p_cmd)
            i2cbm_pkg::CMD_START: begin
                w_sub = p_sub + 3'd1;
                case (p_sub)
                    3'd0: begin
                        w_sda = 1'b0;
                        w_scl = 1'b0;
                    end
                    3'd1: w_sda = 1'b1;
                    3'd2: w_scl = 1'b1;
                    default: begin
                        w_ok  = 1'b0;
                        w_sub = p_sub;
                    end
                endcase
            end
            i2cbm_pkg::CMD_STOP: begin
                w_sub = p_sub + 3'd1;
                case (p_sub)
                    3'd0: begin
                        w_sda = 1'b1;
                        w_scl = 1'b1;
                    end
                    3'd1: w_scl = 1'b0;
                    3'd2: w_sda = 1'b0;
                    default: begin
                        w_ok  = 1'b0;
                        w_sub = p_sub;
                    end
                endcase
            end
            i2cbm_pkg::CMD_WRITE: begin
                if (p_bit >= i2cbm_pkg::BIT_COUNT) begin
                    w_ok = 1'b0;
                end else begin
                    case (p_sub)
                        3'd0: w_sda = (p_bit < i2cbm_pkg::ACK_BIT) ? ~p_shift[w_bit_idx] : 1'b0;
                        3'd1: w_scl = 1'b0;
                        default: begin
                            if (p_bit == i2cbm_pkg::ACK_BIT) begin
                                w_ack = ~i_item.sda_sample;
                            end
                            w_scl = 1'b1;
                        end
                    endcase
                    // three actions per clock
                    if (p_sub >= 3'd2) begin
                        w_sub = '0;
                        w_bit = p_bit + 4'd1;
                    end else begin
                        w_sub = p_sub + 3'd1;
                    end
                end
            end
            i2cbm_pkg::CMD_READ: begin
                if (p_bit < i2cbm_pkg::ACK_BIT) begin
                    if (p_sub == 3'd0) begin
                        if (p_bit == 4'd0) begin
                            w_sda = 1'b0;
                        end
                        w_scl = 1'b0;
                    end else begin
                        w_shift = {p_shift[i2cbm_pkg::DATA_W-2:0], i_item.sda_sample};
                        w_scl   = 1'b1;
                    end
                    // two actions per data clock
                    if (p_sub >= 3'd1) begin
                        w_sub = '0;
                        w_bit = p_bit + 4'd1;
                    end else begin
                        w_sub = p_sub + 3'd1;
                    end
                end else if (p_bit == i2cbm_pkg::ACK_BIT) begin
                    case (p_sub)
                        3'd0: w_sda = p_send_ack;
                        3'd1: w_scl = 1'b0;
                        default: begin
                            w_scl = 1'b1;
                            w_sda = 1'b0;
                        end
                    endcase
                    if (p_sub >= 3'd2) begin
                        w_sub = '0;
                        w_bit = p_bit + 4'd1;
                    end else begin
                        w_sub = p_sub + 3'd1;
                    end
                end else begin
                    w_ok = 1'b0;
                end
            end
            i2cbm_pkg::CMD_CLEAR: begin
                if (p_bit >= i2cbm_pkg::BIT_COUNT) begin
                    w_ok = 1'b0;
                end else begin
                    if (p_sub == 3'd0) begin
                        if (p_bit == 4'd0) begin
                            w_sda = 1'b0;
                        end
                        w_scl = 1'b0;
                    end else begin
                        w_scl = 1'b1;
                    end
                    if (p_sub >= 3'd1) begin
                        w_sub = '0;
                        w_bit = p_bit + 4'd1;
                    end else begin
                        w_sub = p_sub + 3'd1;
                    end
                end
            end
            default: w_ok = 1'b0;
        endcase
    end

    // Accept, wait, act or finish for this tick
    always_comb begin
        n_cmd      = r_cmd;
        n_sub      = r_sub;
        n_bit      = r_bit;
        n_delay    = r_delay;
        n_shift    = r_shift;
        n_scl      = r_scl;
        n_sda      = r_sda;
        n_ack      = r_ack;
        n_send_ack = r_send_ack;
        n_rx       = r_rx;
        w_done     = 1'b0;
        w_rej      = 1'b0;
        if (w_idle) begin
            if (w_valid_cmd) begin
                n_cmd      = i2cbm_pkg::t_cmd'(i_item.mode);
                n_sub      = w_sub;
                n_bit      = w_bit;
                n_shift    = w_shift;
                n_scl      = w_scl;
                n_sda      = w_sda;
                n_ack      = w_ack;
                n_send_ack = i_item.master_ack;
                n_delay    = w_eff_delay;
            end
        end else begin
            w_rej = w_valid_cmd;
            if (r_delay > i2cbm_pkg::DELAY_W'(1)) begin
                n_delay = r_delay - i2cbm_pkg::DELAY_W'(1);
            end else if (w_ok) begin
                n_sub   = w_sub;
                n_bit   = w_bit;
                n_shift = w_shift;
                n_scl   = w_scl;
                n_sda   = w_sda;
                n_ack   = w_ack;
                n_delay = w_eff_delay;
            end else begin
                if (r_cmd == i2cbm_pkg::CMD_READ) begin
                    n_rx = r_shift;
                end
                n_cmd   = i2cbm_pkg::CMD_IDLE;
                n_sub   = '0;
                n_bit   = '0;
                n_delay = '0;
                w_done  = 1'b1;
            end
        end
    end

    // Hold state between steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd      <= i2cbm_pkg::CMD_IDLE;
            r_sub      <= '0;
            r_bit      <= '0;
            r_delay    <= '0;
            r_shift    <= '0;
            r_scl      <= 1'b0;
            r_sda      <= 1'b0;
            r_ack      <= 1'b0;
            r_send_ack <= 1'b0;
            r_rx       <= '0;
        end else if (i_step) begin
            r_cmd      <= n_cmd;
            r_sub      <= n_sub;
            r_bit      <= n_bit;
            r_delay    <= n_delay;
            r_shift    <= n_shift;
            r_scl      <= n_scl;
            r_sda      <= n_sda;
            r_ack      <= n_ack;
            r_send_ack <= n_send_ack;
            r_rx       <= n_rx;
        end
    end

    // Report the state after this tick
    assign o_res.scl_pull_low = n_scl;
    assign o_res.sda_pull_low = n_sda;
    assign o_res.busy_res     = (n_cmd != i2cbm_pkg::CMD_IDLE);
    assign o_res.done_res     = w_done;
    assign o_res.rx_data      = n_rx;
    assign o_res.ack_received = n_ack;
    assign o_res.rejected     = w_rej;

    // Checks
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.done_res |-> !o_res.busy_res)
        else $error("engine reports done while still busy");

    a_rej_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.rejected |-> !w_idle)
        else $error("command rejected while idle");

    a_delay_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_idle |-> (r_delay != '0))
        else $error("busy engine with empty delay counter");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit <= i2cbm_pkg::BIT_COUNT)
        else $error("bit counter out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_cmd) && $stable(r_delay) && $stable(r_scl) && $stable(r_sda))
        else $error("engine state moved without a step");

endmodule

// ----- hdl/i2c_bit_level_master_core.sv -----
// ----------------------------------------------------------------------------
// i2c_bit_level_master_core: streaming I2C bit-level master
// A taken beat goes through the input register, then the result register.
// Throughput: one beat per cycle unless results stall; each is one engine tick.
// The input register and the result register decouple the two sides.
// Reset (synchronous, active low) idles the engine, releases both lines and
// sets the phase delay to 8 ticks.
// ----------------------------------------------------------------------------
module i2c_bit_level_master_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration: phase_delay_ticks
    input  logic                          i_cfg_wr_en,
    input  logic [i2cbm_pkg::DELAY_W-1:0] i_cfg_wr_data,
    // input stream
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // [2:0] mode, [10:3] tx_byte, [11] master_ack, [12] sda_sample, [15:13] zero
    input  logic [i2cbm_pkg::TDATA_W-1:0] i_s_axis_tdata,
    // result stream
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [0] scl_pull_low, [1] sda_pull_low, [2] busy_res, [3] done_res,
    // [11:4] rx_data, [12] ack_received, [13] rejected, [15:14] zero
    output logic [i2cbm_pkg::TDATA_W-1:0] o_m_axis_tdata
);

    logic [i2cbm_pkg::DELAY_W-1:0] r_delay_cfg;
    logic                          r_in_valid;
    i2cbm_pkg::t_item              r_in_item;
    logic                          r_out_valid;
    i2cbm_pkg::t_result            r_out_res;
    i2cbm_pkg::t_result            w_res;
    logic                          w_step;
    logic                          w_in_take;

    // Move a beat into the result register when it is free or being drained
    assign w_step          = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_step;
    assign w_in_take       = i_s_axis_tvalid && o_s_axis_tready;

    // Hold the phase delay register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_cfg <= i2cbm_pkg::DELAY_RESET;
        end else if (i_cfg_wr_en) begin
            r_delay_cfg <= i_cfg_wr_data;
        end
    end

    // Capture input beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_item <= i2cbm_pkg::t_item'(i_s_axis_tdata[i2cbm_pkg::ITEM_W-1:0]);
        end
    end

    i2cbm_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_item  (r_in_item),
        .i_delay (r_delay_cfg),
        .o_res   (w_res)
    );

    // Hold results until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_res <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(i2cbm_pkg::TDATA_W - i2cbm_pkg::RESULT_W){1'b0}}, r_out_res};

endmodule
